@@ hdl/pack_cell_temp_aggregator_assert.svh @@
// Assertion macros for the rack temperature and voltage aggregator.
`ifndef PACK_CELL_TEMP_AGGREGATOR_ASSERT_SVH
`define PACK_CELL_TEMP_AGGREGATOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PCTAGG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pctagg: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define PCTAGG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pctagg: next-cycle check failed");

`endif

@@ hdl/pctagg_pkg.sv @@
// Shared constants and types of the rack temperature and voltage aggregator.
`default_nettype none
package pctagg_pkg;

  localparam int TRAYS   = 16;
  localparam int CELLS   = 16;
  localparam int SENSORS = 4;

  // Pack sum divisor
  localparam int PACK_DIV = 10;

  // Active tray counter saturates here
  localparam logic [4:0] ACT_MAX = 5'd31;

  // Largest constant that scales the active tray count
  localparam int SCALE_MAX = (CELLS > SENSORS) ? CELLS : SENSORS;
  localparam int DVS_MAX   = (31 * SCALE_MAX > PACK_DIV) ? 31 * SCALE_MAX : PACK_DIV;

  // Shared divider widths
  localparam int DVD_W = 25;
  localparam int DVS_W = $clog2(DVS_MAX + 1);

  typedef struct packed {
    logic [3:0]         tray_index;
    logic [1:0]         sensor_index;
    logic               tray_active;
    logic [15:0]        max_cell_mv;
    logic [15:0]        min_cell_mv;
    logic [19:0]        tray_sum_mv;
    logic signed [15:0] module_temp;
    logic               unlock;
  } item_t;

  typedef struct packed {
    logic [15:0]        max_cell;
    logic [4:0]         max_cell_tray;
    logic [15:0]        min_cell;
    logic [4:0]         min_cell_tray;
    logic [23:0]        active_cell_sum;
    logic [4:0]         active_trays;
    logic [22:0]        temp_sum;
    logic signed [15:0] max_temp;
    logic [5:0]         max_where;
    logic signed [15:0] min_temp;
    logic [5:0]         min_where;
    logic [24:0]        all_tray_sum;
    logic               unlock_all;
    logic               temp_seen;
  } acc_state_t;

endpackage
`default_nettype wire

@@ hdl/pctagg_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module pctagg_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire logic [pctagg_pkg::DVD_W-1:0]  dividend,
  input  wire logic [pctagg_pkg::DVS_W-1:0]  divisor,
  output logic                               done,
  output logic [pctagg_pkg::DVD_W-1:0]       quot
);
  import pctagg_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [DVS_W-1:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0]   quo_r, quo_nxt;
  logic [DVS_W:0]     trial;
  logic               fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(DVD_W - 1);
      dvs_nxt = divisor;
      rem_nxt = '0;
      quo_nxt = dividend;
    end else if (run_r) begin
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire

@@ hdl/pctagg_acc.sv @@
// Running extremes and sums over one rack scan.
`default_nettype none
module pctagg_acc (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    take,
  input  wire logic                    clr,
  input  wire pctagg_pkg::item_t       item,
  output pctagg_pkg::acc_state_t       st
);
  import pctagg_pkg::*;

  acc_state_t st_r, st_nxt, st_rst;
  logic       in_range;
  logic [9:0] where_full;
  logic [4:0] tray_one;

  // Reset values of the scan state
  always_comb begin
    st_rst                 = '0;
    st_rst.min_cell        = 16'hFFFF;
    st_rst.max_temp        = 16'sh8000;
    st_rst.min_temp        = 16'sh7FFF;
    st_rst.unlock_all      = 1'b1;
  end

  assign in_range   = (7'(item.tray_index) < 7'(TRAYS)) &&
                      (5'(item.sensor_index) < 5'(SENSORS));
  assign where_full = 10'(item.tray_index) * 10'(SENSORS) + 10'(item.sensor_index);
  assign tray_one   = 5'(item.tray_index) + 5'd1;

  // Fold one item into the scan state
  always_comb begin
    st_nxt = st_r;
    if (take && in_range) begin
      if (item.sensor_index == 2'd0) begin
        st_nxt.all_tray_sum = st_r.all_tray_sum + 25'(item.tray_sum_mv);
        st_nxt.unlock_all   = st_r.unlock_all & item.unlock;
        if (item.tray_active) begin
          if (st_r.active_trays == '0 || item.max_cell_mv > st_r.max_cell) begin
            st_nxt.max_cell      = item.max_cell_mv;
            st_nxt.max_cell_tray = tray_one;
          end
          if (st_r.active_trays == '0 || item.min_cell_mv < st_r.min_cell) begin
            st_nxt.min_cell      = item.min_cell_mv;
            st_nxt.min_cell_tray = tray_one;
          end
          st_nxt.active_cell_sum = st_r.active_cell_sum + 24'(item.tray_sum_mv);
          if (st_r.active_trays != ACT_MAX) begin
            st_nxt.active_trays = st_r.active_trays + 5'd1;
          end
        end
      end
      if (item.tray_active) begin
        st_nxt.temp_sum = st_r.temp_sum + 23'(item.module_temp);
        if (!st_r.temp_seen || item.module_temp > st_r.max_temp) begin
          st_nxt.max_temp  = item.module_temp;
          st_nxt.max_where = where_full[5:0];
        end
        if (!st_r.temp_seen || item.module_temp <= st_r.min_temp) begin
          st_nxt.min_temp  = item.module_temp;
          st_nxt.min_where = where_full[5:0];
        end
        st_nxt.temp_seen = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      st_r <= st_rst;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st = st_r;

endmodule
`default_nettype wire

@@ hdl/pack_cell_temp_aggregator.sv @@
// Top level: rack scan aggregator with a sequencer over one shared divider.
//
//   channel  | handshake             | fields
//   ---------+-----------------------+------------------------------------------
//   in_      | start && !busy        | tray, sensor, active, cells, temp, unlock
//   out_     | out_valid, one cycle  | extremes, averages, pack sum, flags
//
// An item without last is taken and busy stays low.
// An item with last raises busy while three divisions, each made of load, 25
// quotient bits and done, run in turn on the one shared divider.
// The result strobes on the first cycle with busy low again; a new item may be
// taken in that same cycle. The receiver cannot stall the result.
// Reset is synchronous and returns the scan state to its start values.
`default_nettype none
`include "pack_cell_temp_aggregator_assert.svh"
module pack_cell_temp_aggregator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         in_tray_index,
  input  wire logic [1:0]         in_sensor_index,
  input  wire logic               in_tray_active,
  input  wire logic [15:0]        in_max_cell_mv,
  input  wire logic [15:0]        in_min_cell_mv,
  input  wire logic [19:0]        in_tray_sum_mv,
  input  wire logic signed [15:0] in_module_temp,
  input  wire logic               in_unlock,
  input  wire logic               in_last,
  output logic                    out_valid,
  output logic [15:0]             out_max_cell_out,
  output logic [4:0]              out_max_cell_tray,
  output logic [15:0]             out_min_cell_out,
  output logic [4:0]              out_min_cell_tray,
  output logic [15:0]             out_avg_cell,
  output logic signed [15:0]      out_max_temp,
  output logic [5:0]              out_max_temp_where,
  output logic signed [15:0]      out_min_temp,
  output logic [5:0]              out_min_temp_where,
  output logic signed [15:0]      out_avg_temp,
  output logic [20:0]             out_pack_sum,
  output logic [1:0]              out_flags
);
  import pctagg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CELL = 2'd1;
  localparam logic [1:0] S_TEMP = 2'd2;
  localparam logic [1:0] S_PACK = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic              go_r, go_nxt;
  logic              valid_r, valid_nxt;
  logic              accept;
  logic              acc_clr;
  item_t             item;
  acc_state_t        st;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [22:0]       temp_mag;
  logic              temp_neg;
  logic              no_active;
  logic [15:0]       avg_cell_r, avg_cell_nxt;
  logic signed [15:0] avg_temp_r, avg_temp_nxt;

  logic [15:0]        max_cell_r, min_cell_r, avg_cell_o_r;
  logic [4:0]         max_tray_r, min_tray_r;
  logic signed [15:0] max_temp_r, min_temp_r, avg_temp_o_r;
  logic [5:0]         max_where_r, min_where_r;
  logic [20:0]        pack_sum_r;
  logic [1:0]         flags_r;

  assign accept = start && !busy;
  assign busy   = state_r != S_IDLE;

  always_comb begin
    item.tray_index   = in_tray_index;
    item.sensor_index = in_sensor_index;
    item.tray_active  = in_tray_active;
    item.max_cell_mv  = in_max_cell_mv;
    item.min_cell_mv  = in_min_cell_mv;
    item.tray_sum_mv  = in_tray_sum_mv;
    item.module_temp  = in_module_temp;
    item.unlock       = in_unlock;
  end

  pctagg_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (accept),
    .clr   (acc_clr),
    .item  (item),
    .st    (st)
  );

  // Operands of the division that the current step needs
  assign temp_neg  = st.temp_sum[22];
  assign temp_mag  = temp_neg ? 23'(-st.temp_sum) : st.temp_sum;
  assign no_active = st.active_trays == '0;

  always_comb begin
    case (state_r)
      S_CELL: begin
        dvd = DVD_W'(st.active_cell_sum);
        dvs = DVS_W'(DVS_W'(st.active_trays) * DVS_W'(CELLS));
      end
      S_TEMP: begin
        dvd = DVD_W'(temp_mag);
        dvs = DVS_W'(DVS_W'(st.active_trays) * DVS_W'(SENSORS));
      end
      default: begin
        dvd = st.all_tray_sum;
        dvs = DVS_W'(PACK_DIV);
      end
    endcase
  end

  pctagg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go_r),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  // Step through the three divisions after the closing item
  always_comb begin
    state_nxt    = state_r;
    go_nxt       = 1'b0;
    valid_nxt    = 1'b0;
    acc_clr      = 1'b0;
    avg_cell_nxt = avg_cell_r;
    avg_temp_nxt = avg_temp_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_last) begin
          state_nxt = S_CELL;
          go_nxt    = 1'b1;
        end
      end
      S_CELL: begin
        if (div_done) begin
          avg_cell_nxt = (div_q[DVD_W-1:16] != '0) ? 16'hFFFF : div_q[15:0];
          state_nxt    = S_TEMP;
          go_nxt       = 1'b1;
        end
      end
      S_TEMP: begin
        if (div_done) begin
          if (temp_neg) begin
            avg_temp_nxt = (div_q > DVD_W'(32768)) ? 16'sh8000 : -$signed(div_q[15:0]);
          end else begin
            avg_temp_nxt = (div_q > DVD_W'(32767)) ? 16'sh7FFF : $signed(div_q[15:0]);
          end
          state_nxt = S_PACK;
          go_nxt    = 1'b1;
        end
      end
      S_PACK: begin
        if (div_done) begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
          acc_clr   = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      valid_r <= valid_nxt;
    end
    avg_cell_r <= avg_cell_nxt;
    avg_temp_r <= avg_temp_nxt;
  end

  // Load the result registers as the last division finishes
  always_ff @(posedge clk) begin
    if (valid_nxt) begin
      pack_sum_r   <= (div_q[DVD_W-1:21] != '0) ? 21'h1FFFFF : div_q[20:0];
      flags_r      <= {no_active, st.unlock_all};
      max_cell_r   <= no_active ? 16'd0 : st.max_cell;
      max_tray_r   <= no_active ? 5'd0 : st.max_cell_tray;
      min_cell_r   <= no_active ? 16'd0 : st.min_cell;
      min_tray_r   <= no_active ? 5'd0 : st.min_cell_tray;
      avg_cell_o_r <= no_active ? 16'd0 : avg_cell_r;
      avg_temp_o_r <= no_active ? 16'sd0 : avg_temp_r;
      max_temp_r   <= (no_active || !st.temp_seen) ? 16'sd0 : st.max_temp;
      max_where_r  <= (no_active || !st.temp_seen) ? 6'd0 : st.max_where;
      min_temp_r   <= (no_active || !st.temp_seen) ? 16'sd0 : st.min_temp;
      min_where_r  <= (no_active || !st.temp_seen) ? 6'd0 : st.min_where;
    end
  end

  assign out_valid          = valid_r;
  assign out_max_cell_out   = max_cell_r;
  assign out_max_cell_tray  = max_tray_r;
  assign out_min_cell_out   = min_cell_r;
  assign out_min_cell_tray  = min_tray_r;
  assign out_avg_cell       = avg_cell_o_r;
  assign out_max_temp       = max_temp_r;
  assign out_max_temp_where = max_where_r;
  assign out_min_temp       = min_temp_r;
  assign out_min_temp_where = min_where_r;
  assign out_avg_temp       = avg_temp_o_r;
  assign out_pack_sum       = pack_sum_r;
  assign out_flags          = flags_r;

  // Closing item starts the division sequence
  `PCTAGG_ASSERT_NEXT(a_last_goes_busy, accept && in_last, busy && go_r)
  // Divider finishes only inside the sequence
  `PCTAGG_ASSERT_NOW(a_done_in_seq, div_done, state_r != S_IDLE)
  // Result comes with the sequencer back at rest
  `PCTAGG_ASSERT_NOW(a_result_idle, out_valid, state_r == S_IDLE && !go_r)
  // A result strobe lasts one cycle
  `PCTAGG_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)

endmodule
`default_nettype wire
